// ----- hdl/tpbf_pkg.sv -----
// ----------------------------------------------------------------------------
// Tile painted box finder package
// Shared constants, request and result types, and the tile size arithmetic.
// ----------------------------------------------------------------------------
package tpbf_pkg;

   localparam int TILES_ACROSS = 3;
   localparam int TILES_DOWN   = 5;
   localparam int COORD_BITS   = 12;

   // Width of the size registers and of the signed result fields.
   localparam int DIM_BITS   = 13;
   localparam int FIELD_BITS = 13;
   localparam int INDEX_BITS = 8;

   localparam int TC_BITS  = $clog2(TILES_ACROSS + 1);
   localparam int TR_BITS  = $clog2(TILES_DOWN + 1);
   localparam int KW       = (TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1;
   localparam int CMP_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;
   localparam int DIM_LIMIT = 2 ** COORD_BITS;

   // Division by the grid counts is a multiply by a rounded-up reciprocal.
   // With the shift at least the operand width plus the divisor's log2 the
   // quotient is exact for every operand.
   localparam int RECIP_SHIFT  = DIM_BITS + 5;
   localparam int PROD_BITS    = DIM_BITS + RECIP_SHIFT + 1;
   localparam int RECIP_ACROSS = (2 ** RECIP_SHIFT + TILES_ACROSS - 1) / TILES_ACROSS;
   localparam int RECIP_DOWN   = (2 ** RECIP_SHIFT + TILES_DOWN - 1) / TILES_DOWN;

   // Queue depths between front and back, and at the result port.
   localparam int PQ_DEPTH  = 2;
   localparam int PQ_PTR    = (PQ_DEPTH > 1) ? $clog2(PQ_DEPTH) : 1;
   localparam int PQ_CNT    = $clog2(PQ_DEPTH + 1);
   localparam int OUT_DEPTH = 2;
   localparam int OUT_PTR   = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
   localparam int OUT_CNT   = $clog2(OUT_DEPTH + 1);

   // Configuration register map.
   localparam int ADDR_BITS = 3;
   localparam int DATA_BITS = 32;
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;
   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(48);
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(80);

   localparam logic signed [FIELD_BITS-1:0] NOT_FOUND = '1;

   // One classified pixel on its way from the front to the back.
   typedef struct packed {
      logic                  valid;
      logic                  frame_start;
      logic                  painted;
      logic [KW-1:0]         col;
      logic                  last_col;
      logic                  last_row;
      logic [COORD_BITS-1:0] cp;
      logic [COORD_BITS-1:0] rp;
      logic [INDEX_BITS-1:0] tile_index;
      logic                  last_tile;
   } pix_type;

   // One finished box.
   typedef struct packed {
      logic [INDEX_BITS-1:0]         tile_index;
      logic signed [FIELD_BITS-1:0] box_x;
      logic signed [FIELD_BITS-1:0] box_y;
      logic signed [FIELD_BITS-1:0] box_w;
      logic signed [FIELD_BITS-1:0] box_h;
      logic                          last_tile;
   } rsp_type;

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] d);
      logic [DIM_BITS-1:0] r;
      r = d;
      if (CMP_BITS'(d) > CMP_BITS'(DIM_LIMIT)) begin
         r = DIM_BITS'(DIM_LIMIT);
      end
      return r;
   endfunction

   function automatic logic [DIM_BITS-1:0] tiles_across_size(input logic [DIM_BITS-1:0] d);
      logic [PROD_BITS-1:0] prod;
      prod = PROD_BITS'(d) * PROD_BITS'(RECIP_ACROSS);
      return DIM_BITS'(prod >> RECIP_SHIFT);
   endfunction

   function automatic logic [DIM_BITS-1:0] tiles_down_size(input logic [DIM_BITS-1:0] d);
      logic [PROD_BITS-1:0] prod;
      prod = PROD_BITS'(d) * PROD_BITS'(RECIP_DOWN);
      return DIM_BITS'(prod >> RECIP_SHIFT);
   endfunction

endpackage

// ----- hdl/tile_painted_box_finder_top.sv -----
// ----------------------------------------------------------------------------
// Tile painted box finder
// Finds one painted box per tile of a raster-order alpha stream.
// ----------------------------------------------------------------------------
// Usage: pixels enter as requests on the input queue (push, full), one alpha
// value each, with req_frame_start marking the first pixel of an image. The
// image is cut into a fixed grid of tiles sized from image_width and
// image_height, which are written over the APB port (width at 0x0, height at
// 0x4); the user must write them only while the block is idle, which the
// block itself does not enforce. When the last pixel of a tile arrives, one
// request holding that tile's box leaves on the result queue (empty, pop).
// Throughput is one pixel per clock while the middle queue has room. The
// front tracks the raster position and classifies each pixel in the cycle
// it is accepted; a two-entry queue then hands it to the back, which updates
// the box registers of the pixel's tile column. If the receiver stalls, two
// results wait in the result queue and two pixels in the middle queue
// before full rises; pixels that need no work in the back (outside every
// tile) are always taken while the front can accept. Reset clears the
// position and all boxes and restores the default image size of 48 by 80.
// ----------------------------------------------------------------------------
module tile_painted_box_finder_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // Pixel requests.
   input  logic                                  push,
   output logic                                  full,
   input  logic [7:0]                            req_alpha,
   input  logic                                  req_frame_start,
   // Box results.
   output logic                                  empty,
   input  logic                                  pop,
   output logic [tpbf_pkg::INDEX_BITS-1:0]        rsp_tile_index,
   output logic signed [tpbf_pkg::FIELD_BITS-1:0] rsp_box_x,
   output logic signed [tpbf_pkg::FIELD_BITS-1:0] rsp_box_y,
   output logic signed [tpbf_pkg::FIELD_BITS-1:0] rsp_box_w,
   output logic signed [tpbf_pkg::FIELD_BITS-1:0] rsp_box_h,
   output logic                                  rsp_last_tile,
   // Configuration port.
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [tpbf_pkg::ADDR_BITS-1:0]         paddr,
   input  logic [tpbf_pkg::DATA_BITS-1:0]         pwdata,
   output logic [tpbf_pkg::DATA_BITS-1:0]         prdata,
   output logic                                  pready
);

   logic [tpbf_pkg::DIM_BITS-1:0] image_width_ff, image_height_ff;
   logic                          reg_sel, cfg_write, accept;
   logic                          pix_push, q_full, q_head_valid, q_pop;
   tpbf_pkg::pix_type             pix_front, pix_head;
   tpbf_pkg::rsp_type             rsp;

   // Registers are decoded on the word address; the register file never
   // inserts wait states.
   assign pready    = 1'b1;
   assign reg_sel   = paddr[2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= tpbf_pkg::WIDTH_RESET;
         image_height_ff <= tpbf_pkg::HEIGHT_RESET;
      end else if (cfg_write) begin
         case (reg_sel)
            tpbf_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= pwdata[tpbf_pkg::DIM_BITS-1:0];
            tpbf_pkg::REG_IMAGE_HEIGHT: image_height_ff <= pwdata[tpbf_pkg::DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         tpbf_pkg::REG_IMAGE_WIDTH:  prdata = tpbf_pkg::DATA_BITS'(image_width_ff);
         tpbf_pkg::REG_IMAGE_HEIGHT: prdata = tpbf_pkg::DATA_BITS'(image_height_ff);
         default:                    prdata = '0;
      endcase
   end

   // The front stalls only when the middle queue has no room.
   assign full   = q_full;
   assign accept = push && !q_full;

   tpbf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .alpha        (req_alpha),
      .frame_start  (req_frame_start),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .pix_push     (pix_push),
      .pix          (pix_front)
   );

   tpbf_pixq u_pixq (
      .clock      (clock),
      .reset      (reset),
      .push_en    (pix_push),
      .pix_in     (pix_front),
      .full       (q_full),
      .head_valid (q_head_valid),
      .pop_en     (q_pop),
      .pix_out    (pix_head)
   );

   tpbf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (q_head_valid),
      .pix       (pix_head),
      .pix_pop   (q_pop),
      .rsp       (rsp),
      .empty     (empty),
      .pop       (pop)
   );

   assign rsp_tile_index = rsp.tile_index;
   assign rsp_box_x      = rsp.box_x;
   assign rsp_box_y      = rsp.box_y;
   assign rsp_box_w      = rsp.box_w;
   assign rsp_box_h      = rsp.box_h;
   assign rsp_last_tile  = rsp.last_tile;

endmodule

// ----- hdl/tpbf_front.sv -----
// ----------------------------------------------------------------------------
// Tile painted box finder front end
// Tracks the raster position and classifies each accepted pixel by tile.
// ----------------------------------------------------------------------------
module tpbf_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [7:0]                     alpha,
   input  logic                           frame_start,
   input  logic [tpbf_pkg::DIM_BITS-1:0]  image_width,
   input  logic [tpbf_pkg::DIM_BITS-1:0]  image_height,
   output logic                           pix_push,
   output tpbf_pkg::pix_type              pix
);

   logic [tpbf_pkg::COORD_BITS-1:0] col_pos_ff, col_pos_in;
   logic [tpbf_pkg::COORD_BITS-1:0] row_pos_ff, row_pos_in;
   logic [tpbf_pkg::COORD_BITS-1:0] col_tile_ff, col_tile_in;
   logic [tpbf_pkg::COORD_BITS-1:0] row_tile_ff, row_tile_in;
   logic [tpbf_pkg::TC_BITS-1:0]    tile_col_ff, tile_col_in;
   logic [tpbf_pkg::TR_BITS-1:0]    tile_row_ff, tile_row_in;

   logic [tpbf_pkg::DIM_BITS-1:0]   w_img, h_img, tw, th;
   logic [tpbf_pkg::COORD_BITS-1:0] cp, rp, cit, rit;
   logic [tpbf_pkg::TC_BITS-1:0]    tc;
   logic [tpbf_pkg::TR_BITS-1:0]    tr;
   logic                            valid, last_col, last_row;
   logic [15:0]                     idx_full;

   always_comb begin
      w_img = tpbf_pkg::clamp_dim(image_width);
      h_img = tpbf_pkg::clamp_dim(image_height);
      tw    = tpbf_pkg::tiles_across_size(w_img);
      th    = tpbf_pkg::tiles_down_size(h_img);

      // A frame start restarts the raster before the pixel is used.
      cp  = frame_start ? '0 : col_pos_ff;
      rp  = frame_start ? '0 : row_pos_ff;
      cit = frame_start ? '0 : col_tile_ff;
      rit = frame_start ? '0 : row_tile_ff;
      tc  = frame_start ? '0 : tile_col_ff;
      tr  = frame_start ? '0 : tile_row_ff;

      valid = (tw != '0) && (th != '0) &&
              (tc < tpbf_pkg::TC_BITS'(tpbf_pkg::TILES_ACROSS)) &&
              (tr < tpbf_pkg::TR_BITS'(tpbf_pkg::TILES_DOWN));
      last_col = (tpbf_pkg::CMP_BITS'(cit) + 1'b1) >= tpbf_pkg::CMP_BITS'(tw);
      last_row = (tpbf_pkg::CMP_BITS'(rit) + 1'b1) >= tpbf_pkg::CMP_BITS'(th);
      idx_full = 16'(tr) * 16'(tpbf_pkg::TILES_ACROSS) + 16'(tc);

      pix.valid       = valid;
      pix.frame_start = frame_start;
      pix.painted     = (alpha != 8'd0);
      pix.col         = tpbf_pkg::KW'(tc);
      pix.last_col    = last_col;
      pix.last_row    = last_row;
      pix.cp          = cp;
      pix.rp          = rp;
      pix.tile_index  = idx_full[tpbf_pkg::INDEX_BITS-1:0];
      pix.last_tile   = (tc == tpbf_pkg::TC_BITS'(tpbf_pkg::TILES_ACROSS - 1)) &&
                        (tr == tpbf_pkg::TR_BITS'(tpbf_pkg::TILES_DOWN - 1));

      // Only pixels inside a tile, or frame starts, touch the box registers.
      pix_push = accept && (valid || frame_start);

      col_pos_in  = cp;
      row_pos_in  = rp;
      col_tile_in = cit;
      row_tile_in = rit;
      tile_col_in = tc;
      tile_row_in = tr;
      if ((tpbf_pkg::CMP_BITS'(cp) + 1'b1) >= tpbf_pkg::CMP_BITS'(w_img)) begin
         col_pos_in  = '0;
         col_tile_in = '0;
         tile_col_in = '0;
         if ((tpbf_pkg::CMP_BITS'(rp) + 1'b1) >= tpbf_pkg::CMP_BITS'(h_img)) begin
            row_pos_in  = '0;
            row_tile_in = '0;
            tile_row_in = '0;
         end else begin
            row_pos_in = rp + 1'b1;
            if (last_row) begin
               row_tile_in = '0;
               if (tr < tpbf_pkg::TR_BITS'(tpbf_pkg::TILES_DOWN)) begin
                  tile_row_in = tr + 1'b1;
               end
            end else begin
               row_tile_in = rit + 1'b1;
            end
         end
      end else begin
         col_pos_in = cp + 1'b1;
         if (last_col) begin
            col_tile_in = '0;
            if (tc < tpbf_pkg::TC_BITS'(tpbf_pkg::TILES_ACROSS)) begin
               tile_col_in = tc + 1'b1;
            end
         end else begin
            col_tile_in = cit + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
         col_tile_ff <= '0;
         row_tile_ff <= '0;
         tile_col_ff <= '0;
         tile_row_ff <= '0;
      end else if (accept) begin
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
         col_tile_ff <= col_tile_in;
         row_tile_ff <= row_tile_in;
         tile_col_ff <= tile_col_in;
         tile_row_ff <= tile_row_in;
      end
   end

endmodule

// ----- hdl/tpbf_pixq.sv -----
// ----------------------------------------------------------------------------
// Tile painted box finder pixel queue
// Short queue of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module tpbf_pixq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_en,
   input  tpbf_pkg::pix_type pix_in,
   output logic              full,
   output logic              head_valid,
   input  logic              pop_en,
   output tpbf_pkg::pix_type pix_out
);

   tpbf_pkg::pix_type               mem_ff [tpbf_pkg::PQ_DEPTH];
   logic [tpbf_pkg::PQ_PTR-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [tpbf_pkg::PQ_CNT-1:0]     cnt_ff;
   logic                            do_push, do_pop;

   assign full       = (cnt_ff == tpbf_pkg::PQ_CNT'(tpbf_pkg::PQ_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign pix_out    = mem_ff[rd_ptr_ff];
   assign do_push    = push_en && !full;
   assign do_pop     = pop_en && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == tpbf_pkg::PQ_PTR'(tpbf_pkg::PQ_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == tpbf_pkg::PQ_PTR'(tpbf_pkg::PQ_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= pix_in;
      end
   end

   // The fill count never passes the depth.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= tpbf_pkg::PQ_CNT'(tpbf_pkg::PQ_DEPTH))
      else $error("pixel queue count out of range");

   // A push that meets a full queue would lose a pixel.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_en |-> !full)
      else $error("pixel queue pushed while full");

endmodule

// ----- hdl/tpbf_back.sv -----
// ----------------------------------------------------------------------------
// Tile painted box finder back end
// Updates the per-column box registers and queues the finished boxes.
// ----------------------------------------------------------------------------
module tpbf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pix_valid,
   input  tpbf_pkg::pix_type pix,
   output logic              pix_pop,
   output tpbf_pkg::rsp_type rsp,
   output logic              empty,
   input  logic              pop
);

   typedef logic signed [tpbf_pkg::FIELD_BITS-1:0] field_type;

   field_type cx_ff [tpbf_pkg::TILES_ACROSS];
   field_type cy_ff [tpbf_pkg::TILES_ACROSS];
   field_type wf_ff [tpbf_pkg::TILES_ACROSS];
   field_type hf_ff [tpbf_pkg::TILES_ACROSS];

   tpbf_pkg::rsp_type              out_ff [tpbf_pkg::OUT_DEPTH];
   logic [tpbf_pkg::OUT_PTR-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [tpbf_pkg::OUT_CNT-1:0]   out_cnt_ff;

   field_type         cx, cy, wf, hf, cx_in, cy_in, wf_in, hf_in, cpv, rpv;
   logic              fire, emit, out_pop;
   tpbf_pkg::rsp_type out_in;

   always_comb begin
      cx  = pix.frame_start ? tpbf_pkg::NOT_FOUND : cx_ff[pix.col];
      cy  = pix.frame_start ? tpbf_pkg::NOT_FOUND : cy_ff[pix.col];
      wf  = pix.frame_start ? tpbf_pkg::NOT_FOUND : wf_ff[pix.col];
      hf  = pix.frame_start ? tpbf_pkg::NOT_FOUND : hf_ff[pix.col];
      cpv = field_type'(tpbf_pkg::FIELD_BITS'(pix.cp));
      rpv = field_type'(tpbf_pkg::FIELD_BITS'(pix.rp));

      cx_in = cx;
      cy_in = cy;
      wf_in = wf;
      hf_in = hf;
      if (hf >= 0) begin
         // Box already complete for this tile.
      end else if (cx < 0) begin
         if (pix.painted) begin
            cx_in = cpv;
            cy_in = rpv;
            if (pix.last_col) begin
               wf_in = '0;
            end
         end
      end else if (wf < 0) begin
         if (!pix.painted || pix.last_col) begin
            wf_in = cpv - cx;
         end
      end else if (cpv == cx && rpv != cy) begin
         if (!pix.painted || pix.last_row) begin
            hf_in = rpv - cy;
         end
      end

      fire    = pix_valid && (out_cnt_ff != tpbf_pkg::OUT_CNT'(tpbf_pkg::OUT_DEPTH));
      pix_pop = fire;
      emit    = fire && pix.valid && pix.last_col && pix.last_row;

      out_in.tile_index = pix.tile_index;
      out_in.box_x      = cx_in;
      out_in.box_y      = cy_in;
      out_in.box_w      = wf_in;
      out_in.box_h      = hf_in;
      out_in.last_tile  = pix.last_tile;

      empty   = (out_cnt_ff == '0);
      rsp     = out_ff[rd_ptr_ff];
      out_pop = pop && !empty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < tpbf_pkg::TILES_ACROSS; j++) begin
            cx_ff[j] <= tpbf_pkg::NOT_FOUND;
            cy_ff[j] <= tpbf_pkg::NOT_FOUND;
            wf_ff[j] <= tpbf_pkg::NOT_FOUND;
            hf_ff[j] <= tpbf_pkg::NOT_FOUND;
         end
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         if (fire) begin
            for (int j = 0; j < tpbf_pkg::TILES_ACROSS; j++) begin
               if (pix.valid && (pix.col == tpbf_pkg::KW'(j))) begin
                  // An emitted box frees its column for the next tile row.
                  cx_ff[j] <= emit ? tpbf_pkg::NOT_FOUND : cx_in;
                  cy_ff[j] <= emit ? tpbf_pkg::NOT_FOUND : cy_in;
                  wf_ff[j] <= emit ? tpbf_pkg::NOT_FOUND : wf_in;
                  hf_ff[j] <= emit ? tpbf_pkg::NOT_FOUND : hf_in;
               end else if (pix.frame_start) begin
                  cx_ff[j] <= tpbf_pkg::NOT_FOUND;
                  cy_ff[j] <= tpbf_pkg::NOT_FOUND;
                  wf_ff[j] <= tpbf_pkg::NOT_FOUND;
                  hf_ff[j] <= tpbf_pkg::NOT_FOUND;
               end
            end
         end
         if (emit) begin
            wr_ptr_ff <= (wr_ptr_ff == tpbf_pkg::OUT_PTR'(tpbf_pkg::OUT_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + 1'b1;
         end
         if (out_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == tpbf_pkg::OUT_PTR'(tpbf_pkg::OUT_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + 1'b1;
         end
         if (emit && !out_pop) begin
            out_cnt_ff <= out_cnt_ff + 1'b1;
         end else if (out_pop && !emit) begin
            out_cnt_ff <= out_cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff[wr_ptr_ff] <= out_in;
      end
   end

   // The result queue never holds more than its depth.
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= tpbf_pkg::OUT_CNT'(tpbf_pkg::OUT_DEPTH))
      else $error("result queue count out of range");

   // A box that was just emitted is waiting at the result port next cycle.
   a_emit_visible: assert property (@(posedge clock) disable iff (reset)
      emit |=> !empty)
      else $error("emitted box not visible");

   // A width is only ever measured from a found corner.
   a_width_needs_corner: assert property (@(posedge clock) disable iff (reset)
      (emit && out_in.box_x < 0) |-> (out_in.box_w < 0 && out_in.box_h < 0))
      else $error("box size without a corner");

endmodule
